// ----- design/cbfb_pkg.sv -----
// Package for the batch coalescing flush buffer: sizes, codes, queue command and
// inter-module structs, and the saturating counter and ring index helpers. Depends on nothing.
package cbfb_pkg;

	localparam int BUFFER_DEPTH = 32;
	localparam int DATA_W       = 32;
	localparam int BATCH_W      = 32;
	localparam int TOTAL_W      = 16;
	localparam int TIMER_W      = 16;
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	localparam int FUNC_W       = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int S_TDATA_W    = DATA_W + BATCH_W;
	localparam int M_FIELDS_W   = DATA_W + CNT_W + 1;
	localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

	localparam int CQ_DEPTH     = 4;
	localparam int CQ_PTR_W     = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W     = $clog2(CQ_DEPTH + 1);

	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_HWM_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMED_ENABLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

	localparam logic KIND_ACK   = 1'b0;
	localparam logic KIND_ITEM  = 1'b1;

	// At most one queue entry per input: an optional drain followed by an optional ack.
	typedef struct packed {
		logic             do_drain;
		logic [CNT_W-1:0] drain_n;
		logic             drain_final;
		logic             do_ack;
		logic [CNT_W-1:0] ack_count;
		logic             ack_ovf;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [DATA_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic [CNT_W-1:0] used;
		logic [CNT_W-1:0] item_count;
	} front_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_SEND,
		BK_ACK
	} back_state_t;

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] p);
		idx_next = (p == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// ----- design/cbfb_front.sv -----
// Front part: accepts input beats and config writes, keeps the batch counters,
// timer and fill state, writes the item store and queues commands. Uses cbfb_pkg.
module cbfb_front import cbfb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_valid,
	output logic                  s_ready,
	input  logic [FUNC_W-1:0]     func,
	input  logic [DATA_W-1:0]     item_handle,
	input  logic [BATCH_W-1:0]    batch_number,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  cq_full,
	output logic                  cq_push,
	output cmd_t                  cq_cmd,
	output mem_wr_t               mem_wr,
	input  logic                  release_entry,
	output front_status_t         status
);

	logic                 hwm_en_q, timed_en_q;
	logic [TIMER_W-1:0]   timeout_q;
	logic [CNT_W-1:0]     count_q, count_n;
	logic [CNT_W-1:0]     used_q, used_n;
	logic [IDX_W-1:0]     tail_q, tail_n;
	logic [TOTAL_W-1:0]   prev_q, prev_n, cur_q, cur_n;
	logic [BATCH_W-1:0]   id_q, id_n, idm1_q, idm1_n;
	logic                 armed_q, armed_n;
	logic [TIMER_W-1:0]   rem_q, rem_n;
	logic                 accept, cfg_we;

	assign s_ready   = !cq_full && ((used_q != CNT_W'(BUFFER_DEPTH))
	                   || (count_q == CNT_W'(BUFFER_DEPTH)));
	assign cfg_ready = 1'b1;
	assign accept    = s_valid && s_ready;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign status    = '{used: used_q, item_count: count_q};

	always_comb begin
		count_n = count_q;
		tail_n  = tail_q;
		prev_n  = prev_q;
		cur_n   = cur_q;
		id_n    = id_q;
		idm1_n  = idm1_q;
		armed_n = armed_q;
		rem_n   = rem_q;
		cq_push = 1'b0;
		cq_cmd  = '0;
		mem_wr  = '0;
		if (accept) begin
			unique case (func)
				FUNC_APPEND: begin
					if (count_q == CNT_W'(BUFFER_DEPTH)) begin
						// full: drop the item, ack with overflow only
						cq_push          = 1'b1;
						cq_cmd.do_ack    = 1'b1;
						cq_cmd.ack_count = count_q;
						cq_cmd.ack_ovf   = 1'b1;
					end else begin
						mem_wr  = '{en: 1'b1, addr: tail_q, data: item_handle};
						tail_n  = idx_next(tail_q);
						count_n = count_q + 1'b1;
						if (hwm_en_q) begin
							if (id_q != '0 && batch_number == idm1_q) begin
								prev_n = sat_inc(prev_q);
							end else if (batch_number == id_q) begin
								cur_n = sat_inc(cur_q);
							end else if (batch_number > id_q) begin
								prev_n = cur_q;
								cur_n  = TOTAL_W'(1);
								id_n   = batch_number;
								idm1_n = batch_number - 1'b1;
							end
							if (prev_n == '0 || prev_n == cur_n) begin
								cq_cmd.do_drain    = 1'b1;
								cq_cmd.drain_n     = count_n;
								cq_cmd.drain_final = 1'b0;
								count_n = '0;
								armed_n = 1'b0;
								rem_n   = '0;
							end
						end
						if (timed_en_q && count_n != '0 && !armed_n) begin
							armed_n = 1'b1;
							rem_n   = timeout_q;
						end
						cq_push          = 1'b1;
						cq_cmd.do_ack    = 1'b1;
						cq_cmd.ack_count = count_n;
					end
				end
				FUNC_TICK: begin
					if (armed_q) begin
						if (rem_q <= TIMER_W'(1)) begin
							cq_push            = (count_q != '0);
							cq_cmd.do_drain    = 1'b1;
							cq_cmd.drain_n     = count_q;
							cq_cmd.drain_final = 1'b1;
							count_n = '0;
							armed_n = 1'b0;
							rem_n   = '0;
						end else begin
							rem_n = rem_q - 1'b1;
						end
					end
				end
				FUNC_FLUSH: begin
					cq_push            = (count_q != '0);
					cq_cmd.do_drain    = 1'b1;
					cq_cmd.drain_n     = count_q;
					cq_cmd.drain_final = 1'b1;
					count_n = '0;
					armed_n = 1'b0;
					rem_n   = '0;
				end
				default: begin
				end
			endcase
		end
		if (cfg_we && cfg_index == REG_HWM_ENABLE) begin
			prev_n = '0;
			cur_n  = '0;
			id_n   = '0;
			idm1_n = '1;
		end
	end

	always_comb begin
		used_n = used_q;
		if (mem_wr.en && !release_entry) begin
			used_n = used_q + 1'b1;
		end else if (!mem_wr.en && release_entry) begin
			used_n = used_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwm_en_q   <= 1'b0;
			timed_en_q <= 1'b0;
			timeout_q  <= '0;
			count_q    <= '0;
			used_q     <= '0;
			tail_q     <= '0;
			prev_q     <= '0;
			cur_q      <= '0;
			id_q       <= '0;
			idm1_q     <= '1;
			armed_q    <= 1'b0;
			rem_q      <= '0;
		end else begin
			count_q <= count_n;
			used_q  <= used_n;
			tail_q  <= tail_n;
			prev_q  <= prev_n;
			cur_q   <= cur_n;
			id_q    <= id_n;
			idm1_q  <= idm1_n;
			armed_q <= armed_n;
			rem_q   <= rem_n;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HWM_ENABLE:    hwm_en_q   <= cfg_data[0];
					REG_TIMED_ENABLE:  timed_en_q <= cfg_data[0];
					REG_TIMEOUT_TICKS: timeout_q  <= cfg_data[TIMER_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ----- design/cbfb_cmd_fifo.sv -----
// Short command queue between front and back parts.
// Uses cmd_t and queue sizes from cbfb_pkg.
module cbfb_cmd_fifo import cbfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic not_empty,
	input  logic pop,
	output cmd_t head_cmd
);

	cmd_t                entries [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CQ_CNT_W-1:0] fill_q;
	logic                do_push, do_pop;

	assign full      = (fill_q == CQ_CNT_W'(CQ_DEPTH));
	assign not_empty = (fill_q != '0);
	assign head_cmd  = entries[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!do_push && do_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/cbfb_back.sv -----
// Back part: holds the item store ring, pops queued commands, drains items oldest
// first and sends acks through the output register. Uses cbfb_pkg.
module cbfb_back import cbfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_wr_t           mem_wr,
	input  logic              cq_not_empty,
	input  cmd_t              cq_head,
	output logic              cq_pop,
	output logic              release_entry,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_kind,
	output logic [DATA_W-1:0] out_item,
	output logic [CNT_W-1:0]  out_count,
	output logic              out_ovf,
	output logic              out_last
);

	logic [DATA_W-1:0] store [BUFFER_DEPTH];
	logic [DATA_W-1:0] rdata_q;
	back_state_t       state_q, state_n;
	cmd_t              cmd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [IDX_W-1:0]  head_q;
	logic              out_free, rd_en, load_item, load_ack;

	assign out_free = !out_valid || out_ready;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cq_not_empty) begin
					if (cq_head.do_drain && cq_head.drain_n != '0) begin
						state_n = BK_READ;
					end else if (cq_head.do_ack) begin
						state_n = BK_ACK;
					end
				end
			end
			BK_READ: state_n = BK_SEND;
			BK_SEND: begin
				if (out_free) begin
					if (rem_q == CNT_W'(1)) begin
						state_n = cmd_q.do_ack ? BK_ACK : BK_IDLE;
					end else begin
						state_n = BK_READ;
					end
				end
			end
			BK_ACK: begin
				if (out_free) begin
					state_n = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		cq_pop    = 1'b0;
		rd_en     = 1'b0;
		load_item = 1'b0;
		load_ack  = 1'b0;
		unique case (state_q)
			BK_IDLE: cq_pop    = cq_not_empty;
			BK_READ: rd_en     = 1'b1;
			BK_SEND: load_item = out_free;
			BK_ACK:  load_ack  = out_free;
			default: begin
			end
		endcase
	end

	assign release_entry = load_item;

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			store[mem_wr.addr] <= mem_wr.data;
		end
		if (rd_en) begin
			rdata_q <= store[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cq_pop) begin
			cmd_q <= cq_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			rem_q     <= '0;
			head_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cq_pop) begin
				rem_q <= cq_head.drain_n;
			end else if (load_item) begin
				rem_q  <= rem_q - 1'b1;
			end
			if (load_item) begin
				head_q <= idx_next(head_q);
			end
			if (load_item || load_ack) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			out_kind  <= KIND_ITEM;
			out_item  <= rdata_q;
			out_count <= rem_q - 1'b1;
			out_ovf   <= 1'b0;
			out_last  <= cmd_q.drain_final && (rem_q == CNT_W'(1));
		end else if (load_ack) begin
			out_kind  <= KIND_ACK;
			out_item  <= '0;
			out_count <= cmd_q.ack_count;
			out_ovf   <= cmd_q.ack_ovf;
			out_last  <= 1'b1;
		end
	end

endmodule

// ----- design/batch_coalescing_flush_buffer_unit.sv -----
// Batch coalescing flush buffer, top level. An append ack passes the command queue,
// the back's idle and ack states and the output register; each flushed item is a store
// read, then a send. The front takes one input beat a cycle until the 4-entry command
// queue fills or the ring is full but the batch is not; the back runs one command at a time.
// Reset (arst_n, async, low): clears counters, timer, config, pointers and queue;
// the item store is not cleared and needs no clearing pass.
module batch_coalescing_flush_buffer_unit import cbfb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // item_handle[31:0], batch_number[63:32]
	input  logic [FUNC_W-1:0]     s_axis_tuser,  // func[1:0]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,  // flushed_item, buffered_count, overflow
	output logic                  m_axis_tuser,  // kind
	output logic                  m_axis_tlast,  // last_of_run
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// front to queue to back wiring
	logic          cq_full, cq_push, cq_not_empty, cq_pop;
	cmd_t          cq_cmd, cq_head;
	mem_wr_t       mem_wr;
	logic          release_entry;
	front_status_t fstat;

	logic [DATA_W-1:0] out_item;
	logic [CNT_W-1:0]  out_count;
	logic              out_ovf;

	// Front: classify each beat, update batch totals and timer, write the store
	// and queue at most one command (drain and/or ack) per beat.
	cbfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_valid      (s_axis_tvalid),
		.s_ready      (s_axis_tready),
		.func         (s_axis_tuser),
		.item_handle  (s_axis_tdata[DATA_W-1:0]),
		.batch_number (s_axis_tdata[S_TDATA_W-1:DATA_W]),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cq_full      (cq_full),
		.cq_push      (cq_push),
		.cq_cmd       (cq_cmd),
		.mem_wr       (mem_wr),
		.release_entry(release_entry),
		.status       (fstat)
	);

	// Decouple front and back so each side stalls on its own.
	cbfb_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cq_push),
		.push_cmd (cq_cmd),
		.full     (cq_full),
		.not_empty(cq_not_empty),
		.pop      (cq_pop),
		.head_cmd (cq_head)
	);

	// Back: drain from the store ring oldest first, then send the ack.
	cbfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mem_wr       (mem_wr),
		.cq_not_empty (cq_not_empty),
		.cq_head      (cq_head),
		.cq_pop       (cq_pop),
		.release_entry(release_entry),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_kind     (m_axis_tuser),
		.out_item     (out_item),
		.out_count    (out_count),
		.out_ovf      (out_ovf),
		.out_last     (m_axis_tlast)
	);

	// Pack result fields from bit 0 up, zero-fill to a whole byte.
	assign m_axis_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_ovf, out_count, out_item};

`ifndef SYNTHESIS
	// Physical occupancy of the ring never exceeds its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		fstat.used <= CNT_W'(BUFFER_DEPTH))
		else $error("store ring over-filled");

	// Buffered items are always a subset of entries still held in the ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		fstat.item_count <= fstat.used)
		else $error("logical count exceeds ring occupancy");

	// Never write the store when every entry is still waiting to drain.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> (fstat.used < CNT_W'(BUFFER_DEPTH)))
		else $error("store write into a full ring");

	// The front never queues a command the queue cannot hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		cq_push |-> !cq_full)
		else $error("command queue overrun");
`endif

endmodule
